### sv/pft_pkg.sv
// ----------------------------------------------------------------------------
// pft_pkg
// Types and constants shared by the properties-file tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pft_pkg;

	// Characters the parser reacts to
	localparam logic [15:0] CH_TAB    = 16'h0009;
	localparam logic [15:0] CH_LF     = 16'h000A;
	localparam logic [15:0] CH_CR     = 16'h000D;
	localparam logic [15:0] CH_SPACE  = 16'h0020;
	localparam logic [15:0] CH_BANG   = 16'h0021;
	localparam logic [15:0] CH_HASH   = 16'h0023;
	localparam logic [15:0] CH_COLON  = 16'h003A;
	localparam logic [15:0] CH_EQUAL  = 16'h003D;
	localparam logic [15:0] CH_BSLASH = 16'h005C;

	// Command queue between front and back
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW    = 2;

	typedef enum logic [1:0] {
		KIND_KEY     = 2'd0,
		KIND_VALUE   = 2'd1,
		KIND_PAIR    = 2'd2,
		KIND_ABANDON = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		MODE_LINE_START = 3'd0,
		MODE_SKIP_LINE  = 3'd1,
		MODE_KEY        = 3'd2,
		MODE_VALUE      = 3'd3,
		MODE_ESC        = 3'd4,
		MODE_CONT       = 3'd5
	} mode_t;

	typedef enum logic [1:0] {
		TAIL_NONE    = 2'd0,
		TAIL_PAIR    = 2'd1,
		TAIL_ABANDON = 2'd2
	} tail_t;

	typedef enum logic [1:0] {
		BK_RUN  = 2'd0,
		BK_WAIT = 2'd1,
		BK_SPC  = 2'd2
	} back_state_t;

	typedef struct packed {
		logic [15:0] char_code;
		logic        end_of_stream;
	} pft_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] out_char;
		logic        overflow;
		logic        last;
	} pft_result_t;

	// One input's worth of work for the back end:
	// optional clear of held blanks, up to two pushed chars, optional end marker.
	typedef struct packed {
		logic        clr;
		logic        is_value;
		logic        p1_valid;
		logic [15:0] p1_char;
		logic        p2_valid;
		logic [15:0] p2_char;
		tail_t       tail;
	} pft_cmd_t;

	function automatic logic is_blank(input logic [15:0] ch);
		return (ch == CH_SPACE) || (ch == CH_TAB);
	endfunction

	function automatic logic is_eol(input logic [15:0] ch);
		return (ch == CH_CR) || (ch == CH_LF);
	endfunction

endpackage

`default_nettype wire

### sv/properties_file_tokenizer_top.sv
// ----------------------------------------------------------------------------
// properties_file_tokenizer_top
// Results pass through the command queue and then the output register.
// Rate: 1 char per cycle while the command queue has room; flushing held
// blanks, an early overflow emit and a backslash pair make the back end loop.
// Reset: arst_n clears parse mode, queue, held-blank count and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module properties_file_tokenizer_top
	import pft_pkg::*;
#(
	parameter int PENDING_DEPTH = 62
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_ready,
	input  wire pft_item_t item,
	output logic           result_valid,
	input  wire logic      result_ready,
	output pft_result_t    result
);

	logic     q_push;
	pft_cmd_t q_push_cmd;
	logic     q_full;
	logic     q_not_empty;
	pft_cmd_t q_head;
	logic     q_pop;

	pft_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cmd_full   (q_full),
		.cmd_push   (q_push),
		.cmd        (q_push_cmd)
	);

	pft_cmd_fifo u_cmd_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_push_cmd),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head_cmd  (q_head)
	);

	pft_back #(
		.PENDING_DEPTH (PENDING_DEPTH)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_not_empty),
		.cmd          (q_head),
		.cmd_pop      (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

### sv/pft_ram.sv
// ----------------------------------------------------------------------------
// pft_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pft_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 62,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### sv/pft_front.sv
// ----------------------------------------------------------------------------
// pft_front
// Parser front end: tracks line/key/value mode and turns accepted characters
// into commands for the back end; not every character pushes one.
// ----------------------------------------------------------------------------
`default_nettype none

module pft_front
	import pft_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	output logic           item_ready,
	input  wire pft_item_t item,
	input  wire logic      cmd_full,
	output logic           cmd_push,
	output pft_cmd_t       cmd
);

	mode_t       mode_q, mode_d;
	logic        vstart_q, vstart_d;
	logic        acc;
	logic        emit;
	logic [15:0] ch;
	logic        eos;
	logic        blank;
	logic        eol;
	logic        sep;

	assign item_ready = !cmd_full;
	assign acc        = item_valid && item_ready;
	assign cmd_push   = acc && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_LINE_START;
			vstart_q <= 1'b0;
		end else if (acc) begin
			mode_q   <= mode_d;
			vstart_q <= vstart_d;
		end
	end

	always_comb begin
		ch       = item.char_code;
		eos      = item.end_of_stream;
		blank    = is_blank(ch);
		eol      = is_eol(ch);
		sep      = (ch inside {CH_EQUAL, CH_COLON});
		mode_d   = mode_q;
		vstart_d = vstart_q;
		emit     = 1'b0;
		cmd      = '0;
		case (mode_q)
			MODE_LINE_START: begin
				if (eos || blank || eol) begin
					mode_d = MODE_LINE_START;
				end else if (ch inside {CH_HASH, CH_BANG}) begin
					mode_d = MODE_SKIP_LINE;
				end else if (sep) begin
					// empty key
					emit     = 1'b1;
					cmd.clr  = 1'b1;
					mode_d   = MODE_VALUE;
					vstart_d = 1'b0;
				end else begin
					emit         = 1'b1;
					cmd.clr      = 1'b1;
					cmd.p1_valid = 1'b1;
					cmd.p1_char  = ch;
					mode_d       = MODE_KEY;
				end
			end
			MODE_SKIP_LINE: begin
				if (eos || eol) begin
					mode_d = MODE_LINE_START;
				end
			end
			MODE_KEY: begin
				emit = 1'b1;
				if (eos) begin
					cmd.clr  = 1'b1;
					cmd.tail = TAIL_ABANDON;
					mode_d   = MODE_LINE_START;
				end else if (sep) begin
					cmd.clr  = 1'b1;
					mode_d   = MODE_VALUE;
					vstart_d = 1'b0;
				end else begin
					// CR/LF stay in the key
					cmd.p1_valid = 1'b1;
					cmd.p1_char  = ch;
				end
			end
			MODE_VALUE: begin
				cmd.is_value = 1'b1;
				if (eos || eol) begin
					emit     = 1'b1;
					cmd.clr  = 1'b1;
					cmd.tail = TAIL_PAIR;
					mode_d   = MODE_LINE_START;
				end else if (ch == CH_BSLASH) begin
					mode_d = MODE_ESC;
				end else if (blank && !vstart_q) begin
					// leading blanks of a value are dropped
					mode_d = MODE_VALUE;
				end else begin
					emit         = 1'b1;
					cmd.p1_valid = 1'b1;
					cmd.p1_char  = ch;
					if (!blank) begin
						vstart_d = 1'b1;
					end
				end
			end
			MODE_ESC: begin
				cmd.is_value = 1'b1;
				if (eos) begin
					emit         = 1'b1;
					cmd.p1_valid = 1'b1;
					cmd.p1_char  = CH_BSLASH;
					cmd.tail     = TAIL_PAIR;
					mode_d       = MODE_LINE_START;
				end else if (eol) begin
					mode_d = MODE_CONT;
				end else begin
					emit         = 1'b1;
					cmd.p1_valid = 1'b1;
					cmd.p1_char  = CH_BSLASH;
					cmd.p2_valid = 1'b1;
					cmd.p2_char  = ch;
					vstart_d     = 1'b1;
					mode_d       = MODE_VALUE;
				end
			end
			MODE_CONT: begin
				cmd.is_value = 1'b1;
				if (eos) begin
					emit     = 1'b1;
					cmd.clr  = 1'b1;
					cmd.tail = TAIL_PAIR;
					mode_d   = MODE_LINE_START;
				end else if (blank || eol) begin
					mode_d = MODE_CONT;
				end else begin
					emit         = 1'b1;
					cmd.p1_valid = 1'b1;
					cmd.p1_char  = ch;
					vstart_d     = 1'b1;
					mode_d       = MODE_VALUE;
				end
			end
			default: begin
				mode_d = MODE_LINE_START;
			end
		endcase
	end

endmodule

`default_nettype wire

### sv/pft_cmd_fifo.sv
// ----------------------------------------------------------------------------
// pft_cmd_fifo
// Short command queue that decouples the parser front from the emit back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pft_cmd_fifo
	import pft_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire pft_cmd_t push_cmd,
	input  wire logic     pop,
	output logic          full,
	output logic          not_empty,
	output pft_cmd_t      head_cmd
);

	pft_cmd_t           slot_q [CMDQ_DEPTH];
	logic [CMDQ_AW-1:0] wptr_q;
	logic [CMDQ_AW-1:0] rptr_q;
	logic [CMDQ_AW:0]   cnt_q;
	logic               do_pop;

	assign full      = (cnt_q == (CMDQ_AW+1)'(CMDQ_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head_cmd  = slot_q[rptr_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/pft_back.sv
// ----------------------------------------------------------------------------
// pft_back
// Emit back end: runs queued commands, holds trailing blanks in a circular
// buffer, flushes or overflows them, and drives the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pft_back
	import pft_pkg::*;
#(
	parameter int PENDING_DEPTH = 62
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     cmd_valid,
	input  wire pft_cmd_t cmd,
	output logic          cmd_pop,
	output logic          result_valid,
	input  wire logic     result_ready,
	output pft_result_t   result
);

	localparam int PTR_W = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
	localparam int CNT_W = $clog2(PENDING_DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	back_state_t      state_q, state_d;
	logic             done1_q, done1_d;
	logic             done2_q, done2_d;
	logic             clr_done_q, clr_done_d;
	logic             ovf_q, ovf_d;
	logic [PTR_W-1:0] head_q, head_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             out_valid_q;
	pft_result_t      out_q;

	logic             load;
	pft_result_t      load_data;
	logic             out_free;
	logic [CNT_W-1:0] eff_cnt;
	logic             at_p1;
	logic             at_p2;
	logic [15:0]      cur_ch;
	logic             cur_blank;
	logic             more;
	logic             rest_after;
	logic             item_done;
	kind_t            ch_kind;
	logic [PTR_W-1:0] head_inc;
	logic [SUM_W-1:0] wsum;
	logic [SUM_W-1:0] wsum_mod;
	logic             we;
	logic [PTR_W-1:0] waddr;
	logic             wdata;
	logic             rdata;

	pft_ram #(
		.WIDTH (1),
		.DEPTH (PENDING_DEPTH),
		.AW    (PTR_W)
	) u_pend_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (head_d),
		.rdata (rdata)
	);

	assign result_valid = out_valid_q;
	assign result       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_RUN;
			done1_q     <= 1'b0;
			done2_q     <= 1'b0;
			clr_done_q  <= 1'b0;
			ovf_q       <= 1'b0;
			head_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			done1_q    <= done1_d;
			done2_q    <= done2_d;
			clr_done_q <= clr_done_d;
			ovf_q      <= ovf_d;
			head_q     <= head_d;
			cnt_q      <= cnt_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= load_data;
		end
	end

	always_comb begin
		out_free  = !out_valid_q || result_ready;
		eff_cnt   = (cmd.clr && !clr_done_q) ? '0 : cnt_q;
		at_p1     = cmd.p1_valid && !done1_q;
		at_p2     = !at_p1 && cmd.p2_valid && !done2_q;
		cur_ch    = at_p1 ? cmd.p1_char : cmd.p2_char;
		cur_blank = is_blank(cur_ch);
		ch_kind   = cmd.is_value ? KIND_VALUE : KIND_KEY;
		// a blank second char after a flushed first one never emits
		more       = at_p1 ? ((cmd.p2_valid && !is_blank(cmd.p2_char)) ||
		                      (cmd.tail != TAIL_NONE))
		                   : (cmd.tail != TAIL_NONE);
		rest_after = at_p1 ? (cmd.p2_valid || (cmd.tail != TAIL_NONE))
		                   : (cmd.tail != TAIL_NONE);
		head_inc  = (head_q == PTR_W'(PENDING_DEPTH - 1)) ? '0 : head_q + 1'b1;
		wsum      = SUM_W'(head_q) + SUM_W'(eff_cnt);
		wsum_mod  = (wsum >= SUM_W'(PENDING_DEPTH)) ? wsum - SUM_W'(PENDING_DEPTH) : wsum;

		state_d    = state_q;
		done1_d    = done1_q;
		done2_d    = done2_q;
		clr_done_d = clr_done_q;
		ovf_d      = ovf_q;
		head_d     = head_q;
		cnt_d      = cnt_q;
		cmd_pop    = 1'b0;
		item_done  = 1'b0;
		load       = 1'b0;
		load_data  = '0;
		we         = 1'b0;
		waddr      = wsum_mod[PTR_W-1:0];
		wdata      = (cur_ch == CH_TAB);

		case (state_q)
			BK_RUN: begin
				if (cmd_valid) begin
					if (!at_p1 && !at_p2) begin
						if (cmd.tail == TAIL_NONE) begin
							cnt_d   = eff_cnt;
							cmd_pop = 1'b1;
						end else if (out_free) begin
							load           = 1'b1;
							load_data.kind = (cmd.tail == TAIL_PAIR) ? KIND_PAIR
							                                         : KIND_ABANDON;
							load_data.last = 1'b1;
							cnt_d          = '0;
							cmd_pop        = 1'b1;
						end
					end else if (cur_blank) begin
						clr_done_d = 1'b1;
						if (eff_cnt == CNT_W'(PENDING_DEPTH)) begin
							// buffer full: oldest blank goes out early
							cnt_d   = eff_cnt;
							ovf_d   = 1'b1;
							state_d = BK_WAIT;
						end else begin
							we        = 1'b1;
							cnt_d     = eff_cnt + 1'b1;
							item_done = 1'b1;
						end
					end else if (eff_cnt != '0) begin
						clr_done_d = 1'b1;
						cnt_d      = eff_cnt;
						ovf_d      = 1'b0;
						state_d    = BK_WAIT;
					end else if (out_free) begin
						clr_done_d         = 1'b1;
						load               = 1'b1;
						load_data.kind     = ch_kind;
						load_data.out_char = cur_ch;
						load_data.last     = !more;
						cnt_d              = '0;
						item_done          = 1'b1;
					end
				end
			end
			BK_WAIT: begin
				// read of the head entry is in flight
				state_d = BK_SPC;
			end
			BK_SPC: begin
				if (out_free) begin
					load               = 1'b1;
					load_data.kind     = ch_kind;
					load_data.out_char = rdata ? CH_TAB : CH_SPACE;
					load_data.overflow = ovf_q;
					load_data.last     = ovf_q && !more;
					head_d             = head_inc;
					if (ovf_q) begin
						// new blank takes the slot just freed
						we        = 1'b1;
						waddr     = head_q;
						item_done = 1'b1;
						state_d   = BK_RUN;
					end else begin
						cnt_d = cnt_q - 1'b1;
						if (cnt_q == CNT_W'(1)) begin
							state_d = BK_RUN;
						end
					end
				end
			end
			default: begin
				state_d = BK_RUN;
			end
		endcase

		if (item_done) begin
			if (at_p1) begin
				done1_d = 1'b1;
			end else begin
				done2_d = 1'b1;
			end
			if (!rest_after) begin
				cmd_pop = 1'b1;
			end
		end
		if (cmd_pop) begin
			done1_d    = 1'b0;
			done2_d    = 1'b0;
			clr_done_d = 1'b0;
		end
	end

endmodule

`default_nettype wire

### verif/properties_file_tokenizer_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// properties_file_tokenizer testbench
// Sends properties-file text one character per transfer and checks every key,
// value, pair and abandon token against typed-in tokens or a cycle-free parser predictor.
// A short table of hand-picked characters comes first, followed by generated
// entries, comments, escapes, continuations, long blank runs and noise.
// Both sides of the block stall at random.
// ----------------------------------------------------------------------------

module testbench;
	import pft_pkg::*;

	localparam int HOLD_DEPTH   = 62;
	localparam int RANDOM_ITEMS = 360;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 32;
	localparam int USE_PRED     = -1;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	pft_item_t   item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	pft_result_t result;

	properties_file_tokenizer_top #(.PENDING_DEPTH(HOLD_DEPTH)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #1 clk = ~clk;

	// Directed rows: typed_n is the number of typed-in tokens (0 or 1),
	// or USE_PRED when the row is checked against the predictor.
	typedef struct {
		logic [15:0] ch;
		logic        eos;
		int          typed_n;
		kind_t       kind;
		logic [15:0] tok;
	} dir_row_t;

	dir_row_t dir_rows [26];

	// Predictor state
	mode_t       pmode = MODE_LINE_START;
	bit          held_tab [$];
	bit          value_begun = 1'b0;
	pft_result_t step_tokens [$];

	pft_result_t expected_tokens [$];
	pft_item_t   stream [$];

	int error_count = 0;
	int chars_sent = 0;
	int tokens_checked = 0;
	int pairs_seen = 0;
	int abandons_seen = 0;
	int overflows_seen = 0;
	int idle_cycles = 0;
	int ready_hold = 0;
	bit tx_calm = 1'b0;
	bit rx_calm = 1'b0;

	task automatic report_mismatch(string msg);
		$display("ERROR @%0t: %s", $time, msg);
		error_count++;
	endtask

	function automatic bit blank_char(logic [15:0] ch);
		return ch == CH_SPACE || ch == CH_TAB;
	endfunction

	function automatic bit line_end(logic [15:0] ch);
		return ch == CH_CR || ch == CH_LF;
	endfunction

	function automatic void emit_token(kind_t k, logic [15:0] ch, logic ovf);
		pft_result_t tok;
		tok.kind = k;
		tok.out_char = ch;
		tok.overflow = ovf;
		tok.last = 1'b0;
		step_tokens.push_back(tok);
	endfunction

	// Trimming: blanks are held until a non-blank shows up; leading value blanks drop, a full hold emits its oldest
	function automatic void route_char(kind_t k, logic [15:0] ch);
		if (blank_char(ch)) begin
			if (k == KIND_VALUE && !value_begun)
				return;
			if (held_tab.size() >= HOLD_DEPTH) begin
				emit_token(k, held_tab[0] ? CH_TAB : CH_SPACE, 1'b1);
				void'(held_tab.pop_front());
			end
			held_tab.push_back(ch == CH_TAB);
			return;
		end
		foreach (held_tab[i])
			emit_token(k, held_tab[i] ? CH_TAB : CH_SPACE, 1'b0);
		held_tab.delete();
		emit_token(k, ch, 1'b0);
		if (k == KIND_VALUE)
			value_begun = 1'b1;
	endfunction

	function automatic void open_value();
		held_tab.delete();
		value_begun = 1'b0;
		pmode = MODE_VALUE;
	endfunction

	function automatic void close_pair();
		held_tab.delete();
		emit_token(KIND_PAIR, 16'h0000, 1'b0);
		pmode = MODE_LINE_START;
	endfunction

	function automatic void tokenize_char(pft_item_t it);
		logic [15:0] ch;
		logic        eos;
		pft_result_t tail_tok;
		ch = it.char_code;
		eos = it.end_of_stream;
		step_tokens.delete();
		case (pmode)
			MODE_LINE_START: begin
				if (!(eos || blank_char(ch) || line_end(ch))) begin
					if (ch == CH_HASH || ch == CH_BANG) begin
						pmode = MODE_SKIP_LINE;
					end else if (ch == CH_EQUAL || ch == CH_COLON) begin
						open_value();
					end else begin
						held_tab.delete();
						pmode = MODE_KEY;
						route_char(KIND_KEY, ch);
					end
				end
			end
			MODE_SKIP_LINE: begin
				if (eos || line_end(ch))
					pmode = MODE_LINE_START;
			end
			MODE_KEY: begin
				if (eos) begin
					held_tab.delete();
					emit_token(KIND_ABANDON, 16'h0000, 1'b0);
					pmode = MODE_LINE_START;
				end else if (ch == CH_EQUAL || ch == CH_COLON) begin
					open_value();
				end else begin
					route_char(KIND_KEY, ch);
				end
			end
			MODE_VALUE: begin
				if (eos || line_end(ch))
					close_pair();
				else if (ch == CH_BSLASH)
					pmode = MODE_ESC;
				else
					route_char(KIND_VALUE, ch);
			end
			MODE_ESC: begin
				if (eos) begin
					route_char(KIND_VALUE, CH_BSLASH);
					close_pair();
				end else if (line_end(ch)) begin
					pmode = MODE_CONT;
				end else begin
					route_char(KIND_VALUE, CH_BSLASH);
					route_char(KIND_VALUE, ch);
					pmode = MODE_VALUE;
				end
			end
			MODE_CONT: begin
				if (eos) begin
					close_pair();
				end else if (!(blank_char(ch) || line_end(ch))) begin
					// literal, even a backslash
					route_char(KIND_VALUE, ch);
					pmode = MODE_VALUE;
				end
			end
			default: pmode = MODE_LINE_START;
		endcase
		if (step_tokens.size() > 0) begin
			tail_tok = step_tokens.pop_back();
			tail_tok.last = 1'b1;
			step_tokens.push_back(tail_tok);
		end
	endfunction

	// Stream building helpers
	function automatic logic [15:0] pick_text_char();
		int r;
		r = $urandom_range(0, 15);
		if (r == 0)
			return 16'($urandom_range(0, 65535));
		if (r < 11)
			return 16'h0061 + 16'($urandom_range(0, 25));
		return 16'h0030 + 16'($urandom_range(0, 9));
	endfunction

	function automatic void add_text(logic [15:0] ch);
		pft_item_t it;
		it.char_code = ch;
		it.end_of_stream = 1'b0;
		stream.push_back(it);
	endfunction

	function automatic void add_end_mark();
		pft_item_t it;
		it.char_code = 16'($urandom_range(0, 65535));
		it.end_of_stream = 1'b1;
		stream.push_back(it);
	endfunction

	function automatic void add_blanks(int n);
		for (int i = 0; i < n; i++)
			add_text($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
	endfunction

	function automatic logic [15:0] pick_eol();
		return $urandom_range(0, 1) ? CH_CR : CH_LF;
	endfunction

	task automatic send(pft_item_t it, int typed_n, pft_result_t typed);
		int gap;
		if ($urandom_range(0, 23) == 0)
			tx_calm = !tx_calm;
		gap = tx_calm ? 0 : $urandom_range(0, 5);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		chars_sent++;
		tokenize_char(it);
		if (typed_n == USE_PRED) begin
			foreach (step_tokens[i])
				expected_tokens.push_back(step_tokens[i]);
		end else if (typed_n > 0) begin
			expected_tokens.push_back(typed);
		end
		@(negedge clk);
	endtask

	// Receiver stall
	always @(negedge clk) begin
		if (ready_hold > 0) begin
			result_ready <= 1'b0;
			ready_hold--;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : check_results
		pft_result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_tokens.size() == 0) begin
				report_mismatch($sformatf("unexpected token kind %0d char %h",
					result.kind, result.out_char));
			end else begin
				want = expected_tokens.pop_front();
				tokens_checked++;
				if (result.kind != want.kind)
					report_mismatch($sformatf("kind got %0d want %0d",
						result.kind, want.kind));
				if (result.out_char != want.out_char)
					report_mismatch($sformatf("out_char got %h want %h",
						result.out_char, want.out_char));
				if (result.overflow != want.overflow)
					report_mismatch($sformatf("overflow got %b want %b",
						result.overflow, want.overflow));
				if (result.last != want.last)
					report_mismatch($sformatf("last got %b want %b",
						result.last, want.last));
				if (want.kind == KIND_PAIR)
					pairs_seen++;
				if (want.kind == KIND_ABANDON)
					abandons_seen++;
				if (want.overflow)
					overflows_seen++;
			end
			if ($urandom_range(0, 15) == 0)
				rx_calm = !rx_calm;
			ready_hold = rx_calm ? 0 : $urandom_range(0, 5);
		end
	end

	// Watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
			$display("FAILURE");
			$finish;
		end
	end

	initial begin : main
		pft_item_t   it;
		pft_result_t typed;
		int          entry_no;
		int          sel;
		int          n;
		int          r;
		bit          long_key;
		bit          long_value;

		dir_rows = '{
			'{16'h0041,  1'b0, 1,        KIND_KEY,     16'h0041},
			'{16'h0000,  1'b1, 1,        KIND_ABANDON, 16'h0000},
			'{16'h0000,  1'b1, 0,        KIND_KEY,     16'h0000},
			'{CH_HASH,   1'b0, 0,        KIND_KEY,     16'h0000},
			'{16'hFFFF,  1'b0, 0,        KIND_KEY,     16'h0000},
			'{CH_LF,     1'b0, 0,        KIND_KEY,     16'h0000},
			'{CH_BANG,   1'b0, 0,        KIND_KEY,     16'h0000},
			'{CH_CR,     1'b0, 0,        KIND_KEY,     16'h0000},
			'{CH_SPACE,  1'b0, 0,        KIND_KEY,     16'h0000},
			'{16'hFFFF,  1'b0, 1,        KIND_KEY,     16'hFFFF},
			'{CH_SPACE,  1'b0, 0,        KIND_KEY,     16'h0000},
			'{CH_TAB,    1'b0, 0,        KIND_KEY,     16'h0000},
			// CR inside a key flushes the held blanks and is a key char
			'{CH_CR,     1'b0, USE_PRED, KIND_KEY,     16'h0000},
			'{CH_COLON,  1'b0, 0,        KIND_KEY,     16'h0000},
			'{CH_SPACE,  1'b0, 0,        KIND_KEY,     16'h0000},
			'{16'h0000,  1'b0, 1,        KIND_VALUE,   16'h0000},
			'{CH_BSLASH, 1'b0, 0,        KIND_KEY,     16'h0000},
			'{16'h0078,  1'b0, USE_PRED, KIND_KEY,     16'h0000},
			'{CH_BSLASH, 1'b0, 0,        KIND_KEY,     16'h0000},
			'{CH_LF,     1'b0, 0,        KIND_KEY,     16'h0000},
			'{CH_TAB,    1'b0, 0,        KIND_KEY,     16'h0000},
			// backslash right after a continuation is literal
			'{CH_BSLASH, 1'b0, 1,        KIND_VALUE,   CH_BSLASH},
			'{CH_BSLASH, 1'b0, 0,        KIND_KEY,     16'h0000},
			'{16'h0000,  1'b1, USE_PRED, KIND_KEY,     16'h0000},
			// empty key, empty value
			'{CH_EQUAL,  1'b0, 0,        KIND_KEY,     16'h0000},
			'{CH_LF,     1'b0, 1,        KIND_PAIR,    16'h0000}
		};

		entry_no = 0;
		while (stream.size() < RANDOM_ITEMS) begin
			sel = $urandom_range(0, 15);
			long_value = (entry_no % 10 == 3);
			long_key = (entry_no % 10 == 8);
			if (long_value || long_key)
				sel = 15;
			if (sel < 2) begin
				add_text(sel == 0 ? CH_HASH : CH_BANG);
				n = $urandom_range(0, 5);
				repeat (n) add_text(pick_text_char());
				add_text(pick_eol());
			end else if (sel == 2) begin
				n = $urandom_range(3, 8);
				repeat (n) begin
					if ($urandom_range(0, 7) == 0)
						add_end_mark();
					else
						add_text(16'($urandom_range(0, 65535)));
				end
			end else begin
				add_blanks($urandom_range(0, 2));
				n = $urandom_range(0, 6);
				if (long_key && n < 2)
					n = 2;
				for (int k = 0; k < n; k++) begin
					if (long_key && k == 1)
						add_blanks($urandom_range(60, 70));
					r = $urandom_range(0, 15);
					if (r < 2)
						add_blanks(1);
					else if (r == 2)
						add_text(pick_eol());
					else
						add_text(pick_text_char());
				end
				if ($urandom_range(0, 9) == 0) begin
					add_end_mark();
				end else begin
					add_text($urandom_range(0, 1) ? CH_EQUAL : CH_COLON);
					add_blanks($urandom_range(0, 3));
					n = $urandom_range(0, 8);
					if (long_value && n < 2)
						n = 2;
					for (int k = 0; k < n; k++) begin
						if (long_value && k == 1)
							add_blanks($urandom_range(60, 70));
						r = $urandom_range(0, 15);
						if (r < 3) begin
							add_blanks($urandom_range(1, 2));
						end else if (r < 5) begin
							add_text(CH_BSLASH);
							add_text(pick_text_char());
						end else if (r == 5) begin
							add_text(CH_BSLASH);
							add_text(pick_eol());
							add_blanks($urandom_range(0, 3));
							if ($urandom_range(0, 3) == 0)
								add_text(CH_BSLASH);
						end else begin
							add_text(pick_text_char());
						end
					end
					add_blanks($urandom_range(0, 3));
					r = $urandom_range(0, 15);
					if (r == 0) begin
						add_text(CH_BSLASH);
						add_end_mark();
					end else if (r == 1) begin
						add_text(CH_BSLASH);
						add_text(CH_LF);
						add_end_mark();
					end else if (r < 4) begin
						add_end_mark();
					end else if (r < 8) begin
						add_text(CH_CR);
						add_text(CH_LF);
					end else begin
						add_text(pick_eol());
					end
				end
			end
			entry_no++;
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i]) begin
			it.char_code = dir_rows[i].ch;
			it.end_of_stream = dir_rows[i].eos;
			typed.kind = dir_rows[i].kind;
			typed.out_char = dir_rows[i].tok;
			typed.overflow = 1'b0;
			typed.last = 1'b1;
			send(it, dir_rows[i].typed_n, typed);
		end
		foreach (stream[i])
			send(stream[i], USE_PRED, '0);
		item_valid <= 1'b0;

		// the watchdog bounds this wait
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_tokens.size() != 0)
			report_mismatch($sformatf("%0d tokens never arrived", expected_tokens.size()));

		$display("Sent %0d characters (%0d table rows, %0d generated entries).",
			chars_sent, $size(dir_rows), entry_no);
		$display("Checked %0d tokens: %0d pairs, %0d abandoned keys, %0d overflow blanks.",
			tokens_checked, pairs_seen, abandons_seen, overflows_seen);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
sv/pft_pkg.sv
sv/pft_ram.sv
sv/pft_front.sv
sv/pft_cmd_fifo.sv
sv/pft_back.sv
sv/properties_file_tokenizer_top.sv
verif/properties_file_tokenizer_tb.sv
